// ===== hdl/histogram_ratio_pixel_weights_assert.svh =====
// ----------------------------------------------------------------------------
// histogram ratio pixel weights: assertion macros
// concurrent assertion shorthands clocked on the rising edge, reset disabled
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_RATIO_PIXEL_WEIGHTS_ASSERT_SVH
`define HISTOGRAM_RATIO_PIXEL_WEIGHTS_ASSERT_SVH

// consequent checked in the same cycle
`define HRPW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define HRPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hrpw_pkg.sv =====
// ----------------------------------------------------------------------------
// hrpw_pkg
// widths, register map and index helpers shared by the weight lookup block
// ----------------------------------------------------------------------------
`default_nettype none

package hrpw_pkg;

   localparam int MAX_BITS   = 4;
   localparam int IDX_W      = 3 * MAX_BITS;
   localparam int DEPTH      = 1 << IDX_W;
   localparam int CHAN_W     = 4;
   localparam int BIN_W      = 12;
   localparam int PROB_W     = 16;
   localparam int WEIGHT_W   = 16;
   localparam int QUOT_W     = 2 * PROB_W;
   localparam int BPC_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [BPC_W-1:0]     BPC_RESET            = BPC_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_BITS_PER_CHANNEL = CSR_IDX_W'(0);

   // clamp the register into 1..MAX_BITS
   function automatic logic [BPC_W-1:0] eff_bits(input logic [BPC_W-1:0] bpc);
      logic [BPC_W-1:0] b;
      b = bpc;
      if (b == '0) begin
         b = BPC_W'(1);
      end
      if (b > BPC_W'(MAX_BITS)) begin
         b = BPC_W'(MAX_BITS);
      end
      return b;
   endfunction

   // red + green << b + blue << 2b, each channel masked to b bits
   function automatic logic [IDX_W-1:0] flat_index(input logic [BPC_W-1:0] b,
                                                   input logic [CHAN_W-1:0] red,
                                                   input logic [CHAN_W-1:0] green,
                                                   input logic [CHAN_W-1:0] blue);
      logic [CHAN_W-1:0] mask;
      logic [BPC_W:0]    b2;
      mask = (CHAN_W'(1) << b) - CHAN_W'(1);
      b2   = {b, 1'b0};
      return IDX_W'(red & mask)
           + (IDX_W'(green & mask) << b)
           + (IDX_W'(blue & mask) << b2);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hrpw_if.sv =====
// ----------------------------------------------------------------------------
// hrpw channel interfaces
// valid/ready channels for request items and weight result items
// ----------------------------------------------------------------------------
`default_nettype none

interface hrpw_req_if;
   import hrpw_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [BIN_W-1:0]    bin_index;
   logic [PROB_W-1:0]   target_prob;
   logic [PROB_W-1:0]   candidate_prob;
   logic [CHAN_W-1:0]   bin_red;
   logic [CHAN_W-1:0]   bin_green;
   logic [CHAN_W-1:0]   bin_blue;
   logic                last_pixel;

   modport source (output valid, kind, bin_index, target_prob, candidate_prob,
                   bin_red, bin_green, bin_blue, last_pixel, input ready);
   modport sink   (input valid, kind, bin_index, target_prob, candidate_prob,
                   bin_red, bin_green, bin_blue, last_pixel, output ready);
endinterface

interface hrpw_rsp_if;
   import hrpw_pkg::*;

   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight;
   logic                last;

   modport source (output valid, weight, last, input ready);
   modport sink   (input valid, weight, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/histogram_ratio_pixel_weights.sv =====
// ----------------------------------------------------------------------------
// histogram_ratio_pixel_weights
// per-bin weight table sqrt(target/candidate) with streaming pixel lookup
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_ch    in         valid/ready           kind, bin, probs, rgb bins, last
//  rsp_ch    out        valid/ready           weight, last
//  csr_*     in         apb write/read        bits_per_channel
//
//  pixel items: one per cycle while the output is not stalled; the weight passes
//  the ram read register and then the output register; load items with candidate
//  zero write the table directly, others run the bit-serial divider and then the
//  serial square root; req_ch.ready is low while a load computes or when the
//  output register and the ram read stage are both full and rsp_ch.ready is low
//  reset is synchronous; the weight table is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

`include "histogram_ratio_pixel_weights_assert.svh"

module histogram_ratio_pixel_weights (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hrpw_req_if.sink                               req_ch,
   hrpw_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [hrpw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [hrpw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [hrpw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import hrpw_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_ROOT} state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     bin_ff, bin_in;
   logic [BPC_W-1:0]     bpc_ff, bpc_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_last_ff, rd_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [WEIGHT_W-1:0]  rsp_weight_ff, rsp_weight_in;

   logic                 can_move;
   logic                 accept;
   logic                 pix_acc;
   logic                 load_acc;
   logic                 zero_load;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   logic                 div_start;
   logic                 div_done;
   logic [QUOT_W-1:0]    div_quot;
   logic                 sqrt_start;
   logic                 sqrt_done;
   logic [WEIGHT_W-1:0]  sqrt_root;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [WEIGHT_W-1:0]  ram_wdata;
   logic                 ram_re;
   logic [IDX_W-1:0]     ram_raddr;
   logic [WEIGHT_W-1:0]  ram_rdata;

   hrpw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (req_ch.target_prob),
      .denom (req_ch.candidate_prob),
      .done  (div_done),
      .quot  (div_quot)
   );

   hrpw_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quot),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   hrpw_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      can_move     = !rsp_valid_ff || rsp_ch.ready;
      req_ch.ready = (state_ff == ST_IDLE) && (!rd_pend_ff || can_move);
      accept       = req_ch.valid && req_ch.ready;
      pix_acc      = accept && req_ch.kind;
      load_acc     = accept && !req_ch.kind;
      zero_load    = load_acc && (req_ch.candidate_prob == '0);
      div_start    = load_acc && (req_ch.candidate_prob != '0);
      sqrt_start   = (state_ff == ST_DIVIDE) && div_done;

      ram_re    = pix_acc;
      ram_raddr = flat_index(eff_bits(bpc_ff), req_ch.bin_red, req_ch.bin_green,
                             req_ch.bin_blue);
      ram_we    = zero_load || ((state_ff == ST_ROOT) && sqrt_done);
      ram_waddr = zero_load ? IDX_W'(req_ch.bin_index) : bin_ff;
      ram_wdata = zero_load ? '0 : sqrt_root;

      state_in = state_ff;
      bin_in   = bin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               state_in = ST_DIVIDE;
               bin_in   = IDX_W'(req_ch.bin_index);
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // ram read stage drains into the output register when it is free
      rd_pend_in    = pix_acc || (rd_pend_ff && !can_move);
      rd_last_in    = pix_acc ? req_ch.last_pixel : rd_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_last_in   = rsp_last_ff;
      rsp_weight_in = rsp_weight_ff;
      if (rd_pend_ff && can_move) begin
         rsp_valid_in  = 1'b1;
         rsp_last_in   = rd_last_ff;
         rsp_weight_in = ram_rdata;
      end

      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_idx   = csr_paddr[CSR_ADDR_W-1:2];
      bpc_in    = bpc_ff;
      if (csr_write && (csr_idx == REG_BITS_PER_CHANNEL)) begin
         bpc_in = csr_pwdata[BPC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bpc_ff       <= BPC_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bpc_ff       <= bpc_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff        <= bin_in;
      rd_last_ff    <= rd_last_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.weight = rsp_weight_ff;
   assign rsp_ch.last   = rsp_last_ff;
   assign csr_pready    = 1'b1;
   assign csr_prdata    = (csr_idx == REG_BITS_PER_CHANNEL) ? CSR_DATA_W'(bpc_ff) : '0;

   `HRPW_ASSERT_NEXT(a_div_to_root, clock, reset, (state_ff == ST_DIVIDE) && div_done,
      state_ff == ST_ROOT, "divide done did not move to root state")
   `HRPW_ASSERT_SAME(a_root_done_state, clock, reset, sqrt_done, state_ff == ST_ROOT,
      "root done outside root state")
   `HRPW_ASSERT_SAME(a_no_rw_overlap, clock, reset, ram_we, !ram_re,
      "table write and pixel read in the same cycle")
   `HRPW_ASSERT_NEXT(a_read_hold, clock, reset, rd_pend_ff && !can_move,
      rd_pend_ff && $stable(ram_rdata), "stalled table read lost its data")

endmodule

`default_nettype wire

// ===== hdl/hrpw_ram.sv =====
// ----------------------------------------------------------------------------
// hrpw_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hrpw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/hrpw_div.sv =====
// ----------------------------------------------------------------------------
// hrpw_div
// bit-serial restoring divider: (target << 16) / candidate, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hrpw_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hrpw_pkg::PROB_W-1:0]   numer,
   input  wire logic [hrpw_pkg::PROB_W-1:0]   denom,
   output logic                               done,
   output logic      [hrpw_pkg::QUOT_W-1:0]   quot
);
   import hrpw_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic [QUOT_W-1:0] acc_ff, acc_in;
   logic [PROB_W-1:0] rem_ff, rem_in;
   logic [PROB_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [PROB_W:0]   shifted;
   logic [PROB_W+1:0] diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, acc_ff[QUOT_W-1]};
      diff    = {1'b0, shifted} - (PROB_W+2)'(den_ff);
      ge      = !diff[PROB_W+1];

      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         // dividend bits shift out at the top, quotient bits enter at the bottom
         acc_in  = {numer, PROB_W'(0)};
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[QUOT_W-2:0], ge};
         rem_in = ge ? diff[PROB_W-1:0] : shifted[PROB_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = acc_ff;

endmodule

`default_nettype wire

// ===== hdl/hrpw_sqrt.sv =====
// ----------------------------------------------------------------------------
// hrpw_sqrt
// digit-serial integer square root, two radicand bits and one root bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hrpw_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hrpw_pkg::QUOT_W-1:0]   radicand,
   output logic                               done,
   output logic      [hrpw_pkg::WEIGHT_W-1:0] root
);
   import hrpw_pkg::*;

   localparam int STEPS = QUOT_W / 2;
   localparam int ROOT_W = STEPS;
   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(STEPS);

   logic [QUOT_W-1:0] x_ff, x_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W+1:0]  shifted;
   logic [REM_W+1:0]  trial;
   logic [REM_W+2:0]  diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, x_ff[QUOT_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      diff    = {1'b0, shifted} - {1'b0, trial};
      ge      = !diff[REM_W+2];

      x_in    = x_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         x_in    = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[QUOT_W-3:0], 2'b00};
         root_in = {root_ff[ROOT_W-2:0], ge};
         // partial remainder never exceeds twice the partial root
         rem_in  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = WEIGHT_W'(root_ff);

endmodule

`default_nettype wire

// ===== bench/histogram_ratio_pixel_weights_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_ratio_pixel_weights_test
// loads per-bin target/candidate probabilities, streams pixel lookups at
// several channel widths and idle patterns, and checks each returned weight
// and last flag against a predicted weight table
// ----------------------------------------------------------------------------

module histogram_ratio_pixel_weights_test;
   import hrpw_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 80;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct {
      logic                kind;
      logic [BIN_W-1:0]    bin_index;
      logic [PROB_W-1:0]   target_prob;
      logic [PROB_W-1:0]   candidate_prob;
      logic [CHAN_W-1:0]   bin_red;
      logic [CHAN_W-1:0]   bin_green;
      logic [CHAN_W-1:0]   bin_blue;
      logic                last_pixel;
   } weight_request_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } weight_result_type;

   class weight_scoreboard_type;
      logic [WEIGHT_W-1:0] weights[DEPTH];
      bit                  loaded[DEPTH];
      logic [BPC_W-1:0]    bits_reg;
      weight_result_type   pending[$];
      int                  mismatches;

      function new();
         bits_reg   = BPC_RESET;
         mismatches = 0;
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function int unsigned channel_bits();
         if (bits_reg == '0) return 1;
         if (bits_reg > BPC_W'(MAX_BITS)) return MAX_BITS;
         return int'(bits_reg);
      endfunction

      function int unsigned flat_of(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                    logic [CHAN_W-1:0] b);
         int unsigned w;
         int unsigned mask;
         w    = channel_bits();
         mask = (1 << w) - 1;
         return ((r & mask) + ((g & mask) << w) + ((b & mask) << (2 * w))) & (DEPTH - 1);
      endfunction

      // floor(256 * sqrt(t / c)) built bit by bit from the truncated quotient
      function logic [WEIGHT_W-1:0] ratio_weight(logic [PROB_W-1:0] t,
                                                 logic [PROB_W-1:0] c);
         logic [63:0] quot;
         logic [63:0] trial;
         logic [63:0] root;
         if (c == '0) return '0;
         quot = {32'd0, t, 16'd0} / {48'd0, c};
         root = '0;
         for (int i = WEIGHT_W - 1; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= quot) root = trial;
         end
         // root never exceeds 16 bits, so saturation is implicit
         return root[WEIGHT_W-1:0];
      endfunction

      function void note_item(weight_request_type it);
         weight_result_type exp_res;
         int unsigned       idx;
         if (it.kind == KIND_LOAD) begin
            idx          = int'(it.bin_index) & (DEPTH - 1);
            weights[idx] = ratio_weight(it.target_prob, it.candidate_prob);
            loaded[idx]  = 1'b1;
         end else begin
            idx            = flat_of(it.bin_red, it.bin_green, it.bin_blue);
            exp_res.weight = weights[idx];
            exp_res.last   = it.last_pixel;
            pending.push_back(exp_res);
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_weight(logic [WEIGHT_W-1:0] weight, logic last);
         weight_result_type exp_res;
         if (pending.size() == 0) begin
            report($sformatf("weight item with none expected (weight %0d)", weight));
         end else begin
            exp_res = pending.pop_front();
            if (weight !== exp_res.weight) begin
               report($sformatf("weight %0d, expected %0d", weight, exp_res.weight));
            end
            if (last !== exp_res.last) begin
               report($sformatf("last %0b, expected %0b", last, exp_res.last));
            end
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          send_idle_pct;
   int          stall_pct;
   int unsigned cycle_count;
   int unsigned loaded_bins[$];

   weight_scoreboard_type board = new();

   hrpw_req_if req_ch();
   hrpw_rsp_if rsp_ch();

   histogram_ratio_pixel_weights dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin : capture
      weight_request_type seen;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen.kind           = req_ch.kind;
         seen.bin_index      = req_ch.bin_index;
         seen.target_prob    = req_ch.target_prob;
         seen.candidate_prob = req_ch.candidate_prob;
         seen.bin_red        = req_ch.bin_red;
         seen.bin_green      = req_ch.bin_green;
         seen.bin_blue       = req_ch.bin_blue;
         seen.last_pixel     = req_ch.last_pixel;
         board.note_item(seen);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_weight(rsp_ch.weight, rsp_ch.last);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[histogram_ratio_pixel_weights] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_item(input weight_request_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.kind           = it.kind;
      req_ch.bin_index      = it.bin_index;
      req_ch.target_prob    = it.target_prob;
      req_ch.candidate_prob = it.candidate_prob;
      req_ch.bin_red        = it.bin_red;
      req_ch.bin_green      = it.bin_green;
      req_ch.bin_blue       = it.bin_blue;
      req_ch.last_pixel     = it.last_pixel;
      req_ch.valid          = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_load(input logic [BIN_W-1:0] bin, input logic [PROB_W-1:0] t,
                            input logic [PROB_W-1:0] c);
      weight_request_type it;
      bit                 fresh;
      fresh             = !board.loaded[bin];
      it.kind           = KIND_LOAD;
      it.bin_index      = bin;
      it.target_prob    = t;
      it.candidate_prob = c;
      // pixel fields are don't-care on a load
      it.bin_red        = CHAN_W'($urandom);
      it.bin_green      = CHAN_W'($urandom);
      it.bin_blue       = CHAN_W'($urandom);
      it.last_pixel     = 1'($urandom);
      send_item(it);
      if (fresh) loaded_bins.push_back(int'(bin));
   endtask

   task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic last);
      weight_request_type it;
      it.kind           = KIND_PIXEL;
      it.bin_index      = BIN_W'($urandom);
      it.target_prob    = PROB_W'($urandom);
      it.candidate_prob = PROB_W'($urandom);
      it.bin_red        = r;
      it.bin_green      = g;
      it.bin_blue       = b;
      it.last_pixel     = last;
      send_item(it);
   endtask

   task automatic random_load(input bit aimed, input logic [BIN_W-1:0] aim_bin);
      logic [BIN_W-1:0]  bin;
      logic [PROB_W-1:0] t;
      logic [PROB_W-1:0] c;
      int unsigned       reach;
      reach = 1 << (3 * board.channel_bits());
      if (aimed) bin = aim_bin;
      else if ($urandom_range(0, 1) == 0) bin = BIN_W'($urandom);
      else bin = BIN_W'($urandom_range(0, reach - 1));
      case ($urandom_range(0, 9))
         0: c = '0;
         1, 2: c = PROB_W'($urandom_range(1, 255));
         default: c = PROB_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: t = '0;
         1: t = c;
         2: t = '1;
         default: t = PROB_W'($urandom);
      endcase
      send_load(bin, t, c);
   endtask

   // mostly lookups of bins already loaded, with garbage above the channel width
   task automatic random_pixel();
      int unsigned       w;
      int unsigned       mask;
      int unsigned       reach;
      int unsigned       pick;
      bit                found;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      logic              last;
      w     = board.channel_bits();
      mask  = (1 << w) - 1;
      reach = 1 << (3 * w);
      found = 1'b0;
      pick  = 0;
      last  = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 99) < 75 && loaded_bins.size() > 0) begin
         for (int n = 0; n < 8 && !found; n++) begin
            pick = loaded_bins[$urandom_range(0, loaded_bins.size() - 1)];
            if (pick < reach) found = 1'b1;
         end
      end
      if (found) begin
         r = CHAN_W'((pick & mask) | ($urandom & ~mask));
         g = CHAN_W'(((pick >> w) & mask) | ($urandom & ~mask));
         b = CHAN_W'(((pick >> (2 * w)) & mask) | ($urandom & ~mask));
      end else begin
         r = CHAN_W'($urandom);
         g = CHAN_W'($urandom);
         b = CHAN_W'($urandom);
         // never read a bin that holds nothing yet
         if (!board.loaded[board.flat_of(r, g, b)]) begin
            random_load(1'b1, BIN_W'(board.flat_of(r, g, b)));
         end
      end
      send_pixel(r, g, b, last);
   endtask

   task automatic write_bits(input logic [BPC_W-1:0] v);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_BITS_PER_CHANNEL, 2'b00};
      csr_pwdata  = {(CSR_DATA_W - BPC_W)'($urandom), v};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.bits_reg = v;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // loads give no item back, so let a late one finish as well
   task automatic wait_quiet();
      req_ch.valid = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [BPC_W-1:0] bpc, input int send_pct,
                            input int stall, input int count);
      wait_quiet();
      write_bits(bpc);
      send_idle_pct = send_pct;
      stall_pct     = stall;
      repeat (count) begin
         if ($urandom_range(0, 99) < 30) random_load(1'b0, '0);
         else random_pixel();
      end
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      cycle_count           = 0;
      send_idle_pct         = 0;
      stall_pct             = 0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_ch.valid          = 1'b0;
      req_ch.kind           = KIND_LOAD;
      req_ch.bin_index      = '0;
      req_ch.target_prob    = '0;
      req_ch.candidate_prob = '0;
      req_ch.bin_red        = '0;
      req_ch.bin_green      = '0;
      req_ch.bin_blue       = '0;
      req_ch.last_pixel     = 1'b0;
      rsp_ch.ready          = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset width of four bits per channel
      send_load(12'h000, 16'hFFFF, 16'h0001);
      send_load(12'hFFF, 16'h0000, 16'hFFFF);
      send_load(12'h001, 16'hFFFF, 16'h0000);
      send_load(12'h002, 16'h8000, 16'h8000);
      send_load(12'hAAA, 16'h0001, 16'hFFFF);
      send_load(12'h555, 16'hFFFF, 16'hFFFF);
      send_load(12'h123, 16'h0001, 16'h0001);
      send_pixel(4'h0, 4'h0, 4'h0, 1'b0);
      send_pixel(4'hF, 4'hF, 4'hF, 1'b1);
      send_pixel(4'h1, 4'h0, 4'h0, 1'b0);
      send_pixel(4'h2, 4'h0, 4'h0, 1'b0);
      send_pixel(4'hA, 4'hA, 4'hA, 1'b1);
      send_pixel(4'h5, 4'h5, 4'h5, 1'b0);
      send_pixel(4'h3, 4'h2, 4'h1, 1'b0);
      // overwrite a bin and read it straight back
      send_load(12'h000, 16'h0100, 16'hFFFF);
      send_pixel(4'h0, 4'h0, 4'h0, 1'b1);

      run_phase(3'd4, 0, 0, 85);
      run_phase(3'd1, 70, 0, 85);
      run_phase(3'd0, 0, 70, 85);
      run_phase(3'd7, 17, 17, 85);
      run_phase(3'd2, 0, 0, 85);
      run_phase(3'd3, 70, 0, 85);
      run_phase(3'd5, 0, 70, 85);
      run_phase(3'd4, 17, 17, 85);
      wait_quiet();

      if (board.mismatches == 0) begin
         $display("[histogram_ratio_pixel_weights] OK");
      end else begin
         $display("[histogram_ratio_pixel_weights] ERROR");
      end
      $finish;
   end

endmodule
